[rtl/bracket_argument_splitter_core_assert.svh]
// Assertion macros for the bracket argument splitter.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef BRACKET_ARGUMENT_SPLITTER_CORE_ASSERT_SVH
`define BRACKET_ARGUMENT_SPLITTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bas_pkg.sv]
`default_nettype none

package bas_pkg;

  localparam int POS_BITS_DEF      = 16;
  localparam int DEPTH_BITS_DEF    = 8;
  localparam int MAX_POSITIONS_DEF = 1024;

  localparam int POS_W   = 16;
  localparam int ARGC_W  = 11;
  localparam int CLOSE_W = 17;
  localparam int LIMIT_W = 12;
  localparam int CFG_W   = 32;
  localparam int ADDR_W  = 2;

  localparam logic [ADDR_W-1:0] ADDR_POSITION_LIMIT = 2'd0;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_IDX_BITS = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_SEP       = 2'd0,
    KIND_MATCH     = 2'd1,
    KIND_UNMATCHED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_t;

  // Work left by one input item for the back end: an optional separator
  // position followed by an optional summary.
  typedef struct packed {
    logic                rec;
    logic [POS_W-1:0]    rec_pos;
    logic                sum;
    kind_t               sum_kind;
    logic [ARGC_W-1:0]   argc;
    logic [CLOSE_W-1:0]  close_pos;
  } event_t;

endpackage

`default_nettype wire

[rtl/bas_front.sv]
`default_nettype none

module bas_front #(
  parameter int POS_BITS      = bas_pkg::POS_BITS_DEF,
  parameter int DEPTH_BITS    = bas_pkg::DEPTH_BITS_DEF,
  parameter int MAX_POSITIONS = bas_pkg::MAX_POSITIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_ch,
  input  logic [bas_pkg::LIMIT_W-1:0] limit,
  input  logic                        fifo_full,
  output logic                        push,
  output bas_pkg::event_t             ev
);
  import bas_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_POSITIONS + 1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  quote_t                quote_r, quote_nxt;
  logic                  bs_r, bs_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  done_r, done_nxt;

  logic        accept;
  logic        quoted;
  logic        may_rec;
  logic        rec;
  logic        sum;
  logic [31:0] pos_ext;
  logic [31:0] argc_ext;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign push     = accept && (rec || sum);

  always_comb begin
    quote_nxt = quote_r;
    if (in_ch == CH_NUL) begin
      quote_nxt = QUOTE_NONE;
    end else if (!done_r) begin
      case (quote_r)
        QUOTE_NONE: begin
          if (in_ch == CH_SQUOTE) begin
            quote_nxt = QUOTE_SINGLE;
          end else if (in_ch == CH_DQUOTE) begin
            quote_nxt = QUOTE_DOUBLE;
          end
        end
        QUOTE_SINGLE: begin
          if (in_ch == CH_SQUOTE && !bs_r) begin
            quote_nxt = QUOTE_NONE;
          end
        end
        QUOTE_DOUBLE: begin
          if (in_ch == CH_DQUOTE && !bs_r) begin
            quote_nxt = QUOTE_NONE;
          end
        end
        default: quote_nxt = QUOTE_NONE;
      endcase
    end
  end

  always_comb begin
    quoted = (quote_r != QUOTE_NONE);
  end

  assign may_rec = (32'(count_r) < 32'(MAX_POSITIONS)) &&
                   (limit[LIMIT_W-1] || (32'(count_r) < 32'(limit[LIMIT_W-2:0])));

  always_comb begin
    pos_nxt   = pos_r;
    depth_nxt = depth_r;
    bs_nxt    = bs_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    rec       = 1'b0;
    sum       = 1'b0;
    if (in_ch == CH_NUL) begin
      sum       = !done_r;
      pos_nxt   = '0;
      depth_nxt = '0;
      bs_nxt    = 1'b0;
      count_nxt = '0;
      done_nxt  = 1'b0;
    end else if (!done_r) begin
      bs_nxt  = (in_ch == CH_BSLASH);
      pos_nxt = pos_r + 1'b1;
      if (!quoted) begin
        case (in_ch)
          CH_OPEN: begin
            if (depth_r != '1) begin
              depth_nxt = depth_r + 1'b1;
              rec       = (depth_r == '0) && may_rec;
            end
          end
          CH_CLOSE: begin
            if (depth_r != '0) begin
              depth_nxt = depth_r - 1'b1;
              if (depth_r == DEPTH_ONE) begin
                rec      = may_rec;
                sum      = 1'b1;
                done_nxt = 1'b1;
              end
            end
          end
          CH_COMMA: begin
            rec = (depth_r == DEPTH_ONE) && may_rec;
          end
          default: ;
        endcase
      end
      count_nxt = count_r + CNT_BITS'(rec);
    end
  end

  assign pos_ext  = 32'(pos_r);
  assign argc_ext = 32'(count_nxt) - 32'd1;

  always_comb begin
    ev.rec     = rec;
    ev.rec_pos = pos_ext[POS_W-1:0];
    ev.sum     = sum;
    if (in_ch == CH_NUL) begin
      ev.sum_kind  = KIND_UNMATCHED;
      ev.argc      = '1;
      ev.close_pos = '1;
    end else begin
      ev.sum_kind  = KIND_MATCH;
      ev.argc      = argc_ext[ARGC_W-1:0];
      ev.close_pos = {1'b0, pos_ext[CLOSE_W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      depth_r <= '0;
      quote_r <= QUOTE_NONE;
      bs_r    <= 1'b0;
      count_r <= '0;
      done_r  <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      depth_r <= depth_nxt;
      quote_r <= quote_nxt;
      bs_r    <= bs_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/bas_fifo.sv]
`default_nettype none

module bas_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  bas_pkg::event_t                 din,
  input  logic                            pop,
  output bas_pkg::event_t                 dout,
  output logic                            empty,
  output logic                            full,
  output logic [bas_pkg::FIFO_IDX_BITS:0] count
);
  import bas_pkg::*;

  event_t                   entries_r [FIFO_DEPTH];
  logic [FIFO_IDX_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_IDX_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_IDX_BITS:0]   count_r, count_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (FIFO_IDX_BITS + 1)'(FIFO_DEPTH));
  assign count   = count_r;
  assign dout    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_IDX_BITS'(do_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_IDX_BITS'(do_pop);
    count_nxt  = count_r + (FIFO_IDX_BITS + 1)'(do_push) - (FIFO_IDX_BITS + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/bas_back.sv]
`default_nettype none

module bas_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               empty,
  input  bas_pkg::event_t                    head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_kind,
  output logic [bas_pkg::POS_W-1:0]          out_position,
  output logic signed [bas_pkg::ARGC_W-1:0]  out_arg_count,
  output logic signed [bas_pkg::CLOSE_W-1:0] out_closing_pos,
  output logic                               out_last
);
  import bas_pkg::*;

  logic                out_valid_r, out_valid_nxt;
  kind_t               kind_r, kind_nxt;
  logic [POS_W-1:0]    position_r, position_nxt;
  logic [ARGC_W-1:0]   argc_r, argc_nxt;
  logic [CLOSE_W-1:0]  close_r, close_nxt;
  logic                last_r, last_nxt;
  logic                phase_r, phase_nxt;
  logic                load;

  assign load = !empty && (!out_valid_r || out_ready);

  always_comb begin
    pop           = 1'b0;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    position_nxt  = position_r;
    argc_nxt      = argc_r;
    close_nxt     = close_r;
    last_nxt      = last_r;
    out_valid_nxt = load || (out_valid_r && !out_ready);
    if (load) begin
      if (head.rec && !phase_r) begin
        kind_nxt     = KIND_SEP;
        position_nxt = head.rec_pos;
        argc_nxt     = '0;
        close_nxt    = '0;
        last_nxt     = 1'b0;
        if (head.sum) begin
          phase_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        kind_nxt     = head.sum_kind;
        position_nxt = '0;
        argc_nxt     = head.argc;
        close_nxt    = head.close_pos;
        last_nxt     = 1'b1;
        phase_nxt    = 1'b0;
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    position_r <= position_nxt;
    argc_r     <= argc_nxt;
    close_r    <= close_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_position    = position_r;
  assign out_arg_count   = argc_r;
  assign out_closing_pos = close_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

[rtl/bracket_argument_splitter_core.sv]
// Bracket argument splitter. A string enters one character per item on the
// in_ channel, starting at an opening bracket; a zero character ends it.
// Results leave on the out_ channel: one item for the depth-one opening
// bracket, each depth-one comma and the matching closing bracket, then a
// match summary with the argument count and closing position, or an
// unmatched summary if the string ends first. The summary carries out_last.
// The scanner takes one character per cycle while the queue has room and
// writes its results into a four-entry queue; the output stage drains one
// result per cycle while the receiver is ready, so a character that yields
// both a position and a summary leaves as two results. Each result is held
// in the queue and then in the output register. When the receiver stalls,
// the queue fills and in_ready drops once it is full. The position_limit
// register sits at address 0 of the cfg_ port and resets to -1 (no limit).
// Reset is synchronous, clears scanner and queue and leaves in_ready high.
`default_nettype none
`include "bracket_argument_splitter_core_assert.svh"

module bracket_argument_splitter_core #(
  parameter int POS_BITS      = bas_pkg::POS_BITS_DEF,
  parameter int DEPTH_BITS    = bas_pkg::DEPTH_BITS_DEF,
  parameter int MAX_POSITIONS = bas_pkg::MAX_POSITIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_ch,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_kind,
  output logic [bas_pkg::POS_W-1:0]          out_position,
  output logic signed [bas_pkg::ARGC_W-1:0]  out_arg_count,
  output logic signed [bas_pkg::CLOSE_W-1:0] out_closing_pos,
  output logic                               out_last,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bas_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [bas_pkg::CFG_W-1:0]          cfg_pwdata,
  output logic [bas_pkg::CFG_W-1:0]          cfg_prdata,
  output logic                               cfg_pready
);
  import bas_pkg::*;

  logic [LIMIT_W-1:0]     limit_r, limit_nxt;
  logic                   cfg_wr;
  logic                   push;
  logic                   pop;
  logic                   fifo_empty;
  logic                   fifo_full;
  logic [FIFO_IDX_BITS:0] fifo_count;
  event_t                 ev;
  event_t                 head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_POSITION_LIMIT);

  always_comb begin
    limit_nxt = cfg_wr ? cfg_pwdata[LIMIT_W-1:0] : limit_r;
    if (cfg_paddr == ADDR_POSITION_LIMIT) begin
      cfg_prdata = {{(CFG_W - LIMIT_W){limit_r[LIMIT_W-1]}}, limit_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  bas_front #(
    .POS_BITS      (POS_BITS),
    .DEPTH_BITS    (DEPTH_BITS),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_ch),
    .limit     (limit_r),
    .fifo_full (fifo_full),
    .push      (push),
    .ev        (ev)
  );

  bas_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (ev),
    .pop   (pop),
    .dout  (head),
    .empty (fifo_empty),
    .full  (fifo_full),
    .count (fifo_count)
  );

  bas_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (fifo_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_position    (out_position),
    .out_arg_count   (out_arg_count),
    .out_closing_pos (out_closing_pos),
    .out_last        (out_last)
  );

  `BAS_ASSERT_IMP(a_queue_bound, 1'b1, fifo_count <= (FIFO_IDX_BITS + 1)'(FIFO_DEPTH), "queue overfilled")
  `BAS_ASSERT_IMP(a_ready_only_full, !in_ready, fifo_full, "input stalled with queue space left")
  `BAS_ASSERT_IMP(a_last_on_summary, out_valid, out_last == (out_kind != KIND_SEP), "last flag does not match kind")
  `BAS_ASSERT_IMP(a_unmatched_fields, out_valid && out_kind == KIND_UNMATCHED, out_arg_count == '1 && out_closing_pos == '1, "unmatched summary fields wrong")
  `BAS_ASSERT_NXT(a_result_after_push, !fifo_empty && !out_valid, out_valid, "queued result not presented")

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;
  import bas_pkg::*;

  localparam int DEPTH_MAX = (1 << DEPTH_BITS_DEF) - 1;
  localparam int PHASES = 8;
  localparam logic signed [LIMIT_W-1:0] PHASE_LIMITS [PHASES] =
    '{-12'sd1, 12'sd0, 12'sd1, 12'sd1024, 12'sd3, -12'sd1, 12'sd2, 12'sd1024};
  localparam logic [7:0] QUOTED_POOL [6] =
    '{CH_COMMA, CH_OPEN, CH_CLOSE, CH_BSLASH, CH_SQUOTE, CH_DQUOTE};

  typedef struct packed {
    kind_t                     kind;
    logic [POS_W-1:0]          position;
    logic signed [ARGC_W-1:0]  arg_count;
    logic signed [CLOSE_W-1:0] closing_pos;
    logic                      is_last;
  } split_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [7:0]                in_ch;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                out_kind;
  logic [POS_W-1:0]          out_position;
  logic signed [ARGC_W-1:0]  out_arg_count;
  logic signed [CLOSE_W-1:0] out_closing_pos;
  logic                      out_last;
  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [ADDR_W-1:0]         cfg_paddr;
  logic [CFG_W-1:0]          cfg_pwdata;
  logic [CFG_W-1:0]          cfg_prdata;
  logic                      cfg_pready;

  logic [7:0]  pending_chars [$];
  split_t      expected_splits [$];
  int          queued_items;
  int          err_count;
  int          send_idle;
  int          recv_stall;
  logic        in_taken;

  logic [POS_BITS_DEF-1:0]   scan_pos;
  logic [DEPTH_BITS_DEF-1:0] scan_depth;
  quote_t                    scan_quote;
  logic                      scan_bs;
  int                        scan_recorded;
  logic                      scan_matched;
  logic signed [LIMIT_W-1:0] pos_limit;

  bracket_argument_splitter_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_position    (out_position),
    .out_arg_count   (out_arg_count),
    .out_closing_pos (out_closing_pos),
    .out_last        (out_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_error(string msg);
    if (err_count < 40) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    err_count++;
  endtask

  task automatic clear_scan();
    scan_pos = '0;
    scan_depth = '0;
    scan_quote = QUOTE_NONE;
    scan_bs = 1'b0;
    scan_recorded = 0;
    scan_matched = 1'b0;
  endtask

  task automatic push_split(kind_t k, logic [POS_W-1:0] p, logic [ARGC_W-1:0] a,
                            logic [CLOSE_W-1:0] cp, logic l);
    split_t s;
    s.kind = k;
    s.position = p;
    s.arg_count = a;
    s.closing_pos = cp;
    s.is_last = l;
    expected_splits.push_back(s);
  endtask

  task automatic note_position();
    if (scan_recorded < MAX_POSITIONS_DEF && (pos_limit < 0 || scan_recorded < pos_limit)) begin
      push_split(KIND_SEP, POS_W'(scan_pos), '0, '0, 1'b0);
      scan_recorded++;
    end
  endtask

  task automatic scan_char(logic [7:0] c);
    logic       was_bs;
    logic [7:0] closer;
    was_bs = scan_bs;
    if (c == CH_NUL) begin
      if (!scan_matched) begin
        push_split(KIND_UNMATCHED, '0, '1, '1, 1'b1);
      end
      clear_scan();
    end else if (!scan_matched) begin
      scan_bs = (c == CH_BSLASH);
      if (scan_quote != QUOTE_NONE) begin
        closer = (scan_quote == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        if (c == closer && !was_bs) begin
          scan_quote = QUOTE_NONE;
        end
      end else if (c == CH_SQUOTE) begin
        scan_quote = QUOTE_SINGLE;
      end else if (c == CH_DQUOTE) begin
        scan_quote = QUOTE_DOUBLE;
      end else if (c == CH_OPEN) begin
        if (scan_depth != DEPTH_MAX) begin
          scan_depth = scan_depth + 1'b1;
          if (scan_depth == 1) begin
            note_position();
          end
        end
      end else if (c == CH_CLOSE) begin
        if (scan_depth != 0) begin
          scan_depth = scan_depth - 1'b1;
          if (scan_depth == 0) begin
            note_position();
            push_split(KIND_MATCH, '0, ARGC_W'(scan_recorded - 1),
                       CLOSE_W'(scan_pos), 1'b1);
            scan_matched = 1'b1;
          end
        end
      end else if (c == CH_COMMA && scan_depth == 1) begin
        note_position();
      end
      scan_pos = scan_pos + 1'b1;
    end
  endtask

  task automatic check_split();
    split_t want;
    if (expected_splits.size() == 0) begin
      report_error($sformatf("unexpected result kind %0d position %0d", out_kind,
                             out_position));
    end else begin
      want = expected_splits.pop_front();
      if (out_kind !== want.kind)
        report_error($sformatf("kind %0d, expected %0d", out_kind, want.kind));
      if (out_position !== want.position)
        report_error($sformatf("position %0d, expected %0d", out_position,
                               want.position));
      if (out_arg_count !== want.arg_count)
        report_error($sformatf("arg_count %0d, expected %0d", out_arg_count,
                               want.arg_count));
      if (out_closing_pos !== want.closing_pos)
        report_error($sformatf("closing_pos %0d, expected %0d", out_closing_pos,
                               want.closing_pos));
      if (out_last !== want.is_last)
        report_error($sformatf("last %0b, expected %0b", out_last, want.is_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        scan_char(in_ch);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        check_split();
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_valid <= 1'b1;
        in_ch <= pending_chars.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  task automatic queue_char(logic [7:0] c);
    pending_chars.push_back(c);
    queued_items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s.getc(i));
    end
    queue_char(CH_NUL);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(0, 8)) queue_char(8'($urandom_range(1, 255)));
    queue_char(CH_NUL);
  endtask

  task automatic add_quoted();
    logic [7:0] q;
    logic [7:0] c;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    c = q;
    queue_char(q);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1)) c = 8'h61 + 8'($urandom_range(0, 25));
      else c = QUOTED_POOL[$urandom_range(0, 5)];
      queue_char(c);
    end
    if (c == CH_BSLASH) queue_char(8'h78);
    if ($urandom_range(0, 9) != 0) queue_char(q);
  endtask

  // A call with random arguments, mostly closed, then a little
  // trailing junk and the terminator.
  task automatic add_call();
    int depth;
    int r;
    queue_char(CH_OPEN);
    depth = 1;
    repeat ($urandom_range(0, 16)) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        queue_char(8'($urandom_range(1, 255)));
      end else if (r < 55) begin
        queue_char(CH_COMMA);
      end else if (r < 67) begin
        queue_char(CH_OPEN);
        depth++;
      end else if (r < 75) begin
        if (depth > 1) begin
          queue_char(CH_CLOSE);
          depth--;
        end
      end else if (r < 92) begin
        add_quoted();
      end else begin
        queue_char(CH_BSLASH);
        queue_char(8'h61 + 8'($urandom_range(0, 25)));
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      repeat (depth) queue_char(CH_CLOSE);
    end
    repeat ($urandom_range(0, 2)) queue_char(8'($urandom_range(1, 255)));
    queue_char(CH_NUL);
  endtask

  task automatic write_limit(logic signed [LIMIT_W-1:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_POSITION_LIMIT;
    cfg_pwdata <= CFG_W'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    pos_limit = v;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_valid || expected_splits.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    int goal;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ch = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_taken = 1'b0;
    queued_items = 0;
    err_count = 0;
    send_idle = 0;
    recv_stall = 0;
    pos_limit = -12'sd1;
    clear_scan();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_text("(a,b)");
    send_text("('x\\',y',\"p\\\"q,\",z)");
    send_text("(a,(b");
    send_text("(x)y,()");
    send_text(")(,)");
    send_text("(\"open,");
    send_text({"(", 8'hFF, 8'h80, ",", 8'h7F, 8'h01, ")"});
    send_text("");

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_limit(PHASE_LIMITS[p]);
      case (p % 4)
        0: begin
          send_idle = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle = 81;
          recv_stall = 0;
        end
        2: begin
          send_idle = 0;
          recv_stall = 81;
        end
        default: begin
          send_idle = 15;
          recv_stall = 15;
        end
      endcase
      goal = queued_items + 90;
      while (queued_items < goal) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        else add_call();
      end
    end

    wait_idle();
    if (expected_splits.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_splits.size()));
    end
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire

[bracket_argument_splitter_core.f]
+incdir+rtl
rtl/bas_pkg.sv
rtl/bas_front.sv
rtl/bas_fifo.sv
rtl/bas_back.sv
rtl/bracket_argument_splitter_core.sv
test/tb_top.sv
